>>> design/aspect_fit_nearest_scaler_defines.svh
// Assertion macros used by the scaler checker
`ifndef ASPECT_FIT_NEAREST_SCALER_DEFINES_SVH
`define ASPECT_FIT_NEAREST_SCALER_DEFINES_SVH

// same-cycle implication on i_clk, off during reset
`define AFNS_AST_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scaler check failed");

// next-cycle implication on i_clk, off during reset
`define AFNS_AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scaler check failed");

`endif

>>> design/afns_pkg.sv
// Shared constants, types and helpers of the aspect-fit scaler
package afns_pkg;

    localparam int SRC_DIM_MAX = 256;
    localparam int OUT_DIM_MAX = 4096;

    localparam int SRC_AW = $clog2(SRC_DIM_MAX);
    localparam int MEM_AW = 2 * SRC_AW;
    localparam int SW_W   = $clog2(SRC_DIM_MAX + 1);
    localparam int OW_W   = $clog2(OUT_DIM_MAX + 1);
    localparam int SCR_W  = SW_W + OW_W;
    localparam int X0_W   = SCR_W + 1;
    localparam int DX_W   = X0_W + 1;
    localparam int NUM_W  = DX_W + SW_W + 1;
    localparam int LIM_W  = SW_W + SCR_W;

    localparam int CRD_W  = 12;
    localparam int PIX_W  = 24;
    localparam int OREG_W = 13;
    localparam int SREG_W = 9;
    localparam int CADR_W = 3;

    localparam logic [CADR_W-1:0] REG_OUT_WIDTH   = 3'd0;
    localparam logic [CADR_W-1:0] REG_OUT_HEIGHT  = 3'd1;
    localparam logic [CADR_W-1:0] REG_SRC_WIDTH   = 3'd2;
    localparam logic [CADR_W-1:0] REG_SRC_HEIGHT  = 3'd3;
    localparam logic [CADR_W-1:0] REG_KEEP_ASPECT = 3'd4;
    localparam logic [CADR_W-1:0] REG_FIT_AXIS    = 3'd5;

    typedef struct packed {
        logic [SCR_W-1:0]        scr_w;
        logic [SCR_W-1:0]        scr_h;
        logic signed [X0_W-1:0]  x0;
        logic signed [X0_W-1:0]  y0;
        logic [LIM_W-1:0]        lim_x;
        logic [LIM_W-1:0]        lim_y;
        logic                    bad;
    } t_geom;

    typedef struct packed {
        logic              mode;
        logic              ok;
        logic              lok;
        logic [MEM_AW-1:0] laddr;
        logic [PIX_W-1:0]  pix;
    } t_carry;

    function automatic logic [OW_W-1:0] sat_out(input logic [OREG_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'(OUT_DIM_MAX)) w = 32'(OUT_DIM_MAX);
        return OW_W'(w);
    endfunction

    function automatic logic [SW_W-1:0] sat_src(input logic [SREG_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'(SRC_DIM_MAX)) w = 32'(SRC_DIM_MAX);
        return SW_W'(w);
    endfunction

endpackage

>>> design/aspect_fit_nearest_scaler.sv
// Top level of the aspect-fit nearest-neighbour scaler with pixel memory
// Result word passes 12 register stages (3 map, 8 divider, one memory read) after the
// input word is taken; one word per cycle while output is taken and no setup is pending.
// Load and fetch share the pipeline; the memory is touched at one stage, so order holds.
// After reset and config writes input is held off during setup (divide only with keep_aspect);
// a write during setup makes it run again once it ends. Reset is synchronous, active low.
module aspect_fit_nearest_scaler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // coord_x[11:0], coord_y[23:12], pixel_in[47:24]
    input  logic        i_s_tuser,   // mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // pixel_out[23:0]
    output logic        o_m_tuser,   // inside_res
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_data
);
    import afns_pkg::*;

    localparam int NST = SRC_AW;

    logic [OREG_W-1:0] r_out_w, r_out_h;
    logic [SREG_W-1:0] r_src_w, r_src_h;
    logic              r_keep, r_fit, r_pend;
    logic              w_busy, w_adv, w_acc;
    t_geom             w_geom;
    logic [OW_W-1:0]   w_ow, w_oh;
    logic [SW_W-1:0]   w_sw, w_sh;

    assign w_ow = sat_out(r_out_w);
    assign w_oh = sat_out(r_out_h);
    assign w_sw = sat_src(r_src_w);
    assign w_sh = sat_src(r_src_h);

    assign o_cfg_ready = 1'b1;

    // pending setup request stays until the setup unit picks it up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_w <= OREG_W'(640);
            r_out_h <= OREG_W'(480);
            r_src_w <= SREG_W'(256);
            r_src_h <= SREG_W'(256);
            r_keep  <= 1'b0;
            r_fit   <= 1'b0;
            r_pend  <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                r_pend <= 1'b1;
                case (i_cfg_addr)
                    REG_OUT_WIDTH:   r_out_w <= i_cfg_data;
                    REG_OUT_HEIGHT:  r_out_h <= i_cfg_data;
                    REG_SRC_WIDTH:   r_src_w <= i_cfg_data[SREG_W-1:0];
                    REG_SRC_HEIGHT:  r_src_h <= i_cfg_data[SREG_W-1:0];
                    REG_KEEP_ASPECT: r_keep  <= i_cfg_data[0];
                    REG_FIT_AXIS:    r_fit   <= i_cfg_data[0];
                    default: ;
                endcase
            end else if (!w_busy) begin
                r_pend <= 1'b0;
            end
        end
    end

    afns_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_pend),
        .i_ow    (w_ow),
        .i_oh    (w_oh),
        .i_sw    (w_sw),
        .i_sh    (w_sh),
        .i_keep  (r_keep),
        .i_fit   (r_fit),
        .o_busy  (w_busy),
        .o_geom  (w_geom)
    );

    // whole pipeline moves together when the output register can take a word
    logic r_ovalid, r_oin;
    logic [PIX_W-1:0] r_opix;
    assign w_adv      = !r_ovalid || i_m_tready;
    assign o_s_tready = w_adv && !w_busy && !r_pend;
    assign w_acc      = i_s_tvalid && o_s_tready;

    logic [CRD_W-1:0] w_cx, w_cy;
    assign w_cx = i_s_tdata[CRD_W-1:0];
    assign w_cy = i_s_tdata[2*CRD_W-1:CRD_W];

    // stage A: offsets from image start
    logic                   r_va, r_vb, r_vc;
    t_carry                 r_ca, r_cb, r_cc;
    logic signed [DX_W-1:0] r_dx, r_dy;
    logic signed [NUM_W-1:0] r_nx, r_ny;
    logic [NUM_W-1:0]       r_mx, r_my;
    t_carry                 w_ca, w_cc;

    always_comb begin
        w_ca.mode  = i_s_tuser;
        w_ca.ok    = (32'(w_cx) < 32'(w_ow)) && (32'(w_cy) < 32'(w_oh)) && !w_geom.bad;
        w_ca.lok   = (32'(w_cx) < 32'(SRC_DIM_MAX)) && (32'(w_cy) < 32'(SRC_DIM_MAX));
        w_ca.laddr = {w_cy[SRC_AW-1:0], w_cx[SRC_AW-1:0]};
        w_ca.pix   = i_s_tdata[2*CRD_W+PIX_W-1:2*CRD_W];
    end

    // stage C: magnitude and range; negative below one step maps to 0
    always_comb begin
        w_cc    = r_cb;
        w_cc.ok = r_cb.ok &&
                  (r_nx[NUM_W-1] ? (NUM_W'(-r_nx) < NUM_W'(w_geom.scr_w))
                                 : (NUM_W'(r_nx) < NUM_W'(w_geom.lim_x))) &&
                  (r_ny[NUM_W-1] ? (NUM_W'(-r_ny) < NUM_W'(w_geom.scr_h))
                                 : (NUM_W'(r_ny) < NUM_W'(w_geom.lim_y)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (w_adv) begin
            r_va <= w_acc;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ca <= w_ca;
            r_dx <= signed'(DX_W'(w_cx)) - DX_W'(w_geom.x0);
            r_dy <= signed'(DX_W'(w_cy)) - DX_W'(w_geom.y0);
            // stage B: scale by source size
            r_cb <= r_ca;
            r_nx <= NUM_W'(r_dx) * signed'(NUM_W'(w_sw));
            r_ny <= NUM_W'(r_dy) * signed'(NUM_W'(w_sh));
            r_cc <= w_cc;
            r_mx <= r_nx[NUM_W-1] ? NUM_W'(-r_nx) : NUM_W'(r_nx);
            r_my <= r_ny[NUM_W-1] ? NUM_W'(-r_ny) : NUM_W'(r_ny);
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    logic              r_vd [NST];
    t_carry            r_cd [NST];
    logic [NUM_W-1:0]  r_rx [NST];
    logic [NUM_W-1:0]  r_ry [NST];
    logic [SRC_AW-1:0] r_qx [NST];
    logic [SRC_AW-1:0] r_qy [NST];
    logic [NUM_W-1:0]  n_rx [NST];
    logic [NUM_W-1:0]  n_ry [NST];
    logic [SRC_AW-1:0] n_qx [NST];
    logic [SRC_AW-1:0] n_qy [NST];

    always_comb begin
        logic [NUM_W-1:0]  rx, ry, dvx, dvy;
        logic [SRC_AW-1:0] qx, qy;
        for (int i = 0; i < NST; i++) begin
            rx  = (i == 0) ? r_mx : r_rx[(i == 0) ? 0 : i-1];
            ry  = (i == 0) ? r_my : r_ry[(i == 0) ? 0 : i-1];
            qx  = (i == 0) ? '0 : r_qx[(i == 0) ? 0 : i-1];
            qy  = (i == 0) ? '0 : r_qy[(i == 0) ? 0 : i-1];
            dvx = NUM_W'(w_geom.scr_w) << (NST - 1 - i);
            dvy = NUM_W'(w_geom.scr_h) << (NST - 1 - i);
            n_qx[i] = qx;
            n_qy[i] = qy;
            n_rx[i] = rx;
            n_ry[i] = ry;
            if (rx >= dvx) begin
                n_rx[i] = rx - dvx;
                n_qx[i][NST-1-i] = 1'b1;
            end
            if (ry >= dvy) begin
                n_ry[i] = ry - dvy;
                n_qy[i][NST-1-i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) r_vd[i] <= 1'b0;
        end else if (w_adv) begin
            for (int i = 0; i < NST; i++) r_vd[i] <= (i == 0) ? r_vc : r_vd[(i == 0) ? 0 : i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NST; i++) begin
                r_cd[i] <= (i == 0) ? r_cc : r_cd[(i == 0) ? 0 : i-1];
                r_rx[i] <= n_rx[i];
                r_ry[i] <= n_ry[i];
                r_qx[i] <= n_qx[i];
                r_qy[i] <= n_qy[i];
            end
        end
    end

    // pixel memory: loads write and fetches read at this one stage
    logic [PIX_W-1:0] r_mem [2**MEM_AW];
    t_carry           w_cl;
    logic             w_vl;
    assign w_cl = r_cd[NST-1];
    assign w_vl = r_vd[NST-1];

    always_ff @(posedge i_clk) begin
        if (w_adv && w_vl) begin
            if (!w_cl.mode) begin
                if (w_cl.lok) r_mem[w_cl.laddr] <= w_cl.pix;
            end else begin
                r_opix <= r_mem[{r_qy[NST-1], r_qx[NST-1]}];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_oin    <= 1'b0;
        end else if (w_adv) begin
            r_ovalid <= w_vl && w_cl.mode;
            r_oin    <= w_cl.ok;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_oin;
    assign o_m_tdata  = r_oin ? r_opix : '0;

endmodule

>>> design/afns_setup.sv
// Geometry setup: fitted size by a serial divider, offsets and limits
module afns_setup (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [afns_pkg::OW_W-1:0] i_ow,
    input  logic [afns_pkg::OW_W-1:0] i_oh,
    input  logic [afns_pkg::SW_W-1:0] i_sw,
    input  logic [afns_pkg::SW_W-1:0] i_sh,
    input  logic                     i_keep,
    input  logic                     i_fit,
    output logic                     o_busy,
    output afns_pkg::t_geom          o_geom
);
    import afns_pkg::*;

    localparam int CNT_W = $clog2(SCR_W + 1);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_LIM  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [SW_W-1:0]  r_rem;
    logic [SCR_W-1:0] r_quo;
    logic [SW_W-1:0]  r_div;
    t_geom            r_geom;

    logic [SW_W:0]    w_trial;
    logic             w_ge;
    logic [SCR_W-1:0] w_scr_w, w_scr_h;
    logic signed [X0_W-1:0] w_x0, w_y0;

    assign w_trial = {r_rem, r_quo[SCR_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_comb begin
        w_scr_w = SCR_W'(i_ow);
        w_scr_h = SCR_W'(i_oh);
        w_x0    = '0;
        w_y0    = '0;
        if (i_keep) begin
            if (!i_fit) begin
                w_scr_h = r_quo;
                w_y0 = signed'(X0_W'(i_oh >> 1)) - signed'(X0_W'(r_quo >> 1));
            end else begin
                w_scr_w = r_quo;
                w_x0 = signed'(X0_W'(i_ow >> 1)) - signed'(X0_W'(r_quo >> 1));
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_LOAD;
            S_LOAD: n_state = i_keep ? S_DIV : S_FIN;
            S_DIV:  if (r_cnt == CNT_W'(SCR_W - 1)) n_state = S_FIN;
            S_FIN:  n_state = S_LIM;
            S_LIM:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DIV) r_cnt <= r_cnt + 1'b1;
            else r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                r_rem <= '0;
                r_quo <= i_fit ? SCR_W'(i_sw * i_oh) : SCR_W'(i_sh * i_ow);
                r_div <= i_fit ? i_sh : i_sw;
            end
            S_DIV: begin
                r_rem <= w_ge ? SW_W'(w_trial - {1'b0, r_div}) : SW_W'(w_trial);
                r_quo <= {r_quo[SCR_W-2:0], w_ge};
            end
            S_FIN: begin
                r_geom.scr_w <= w_scr_w;
                r_geom.scr_h <= w_scr_h;
                r_geom.x0    <= w_x0;
                r_geom.y0    <= w_y0;
                r_geom.bad   <= (i_ow == '0) || (i_oh == '0) || (i_sw == '0) ||
                                (i_sh == '0) || (w_scr_w == '0) || (w_scr_h == '0);
            end
            S_LIM: begin
                r_geom.lim_x <= LIM_W'(i_sw * r_geom.scr_w);
                r_geom.lim_y <= LIM_W'(i_sh * r_geom.scr_h);
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_geom = r_geom;

endmodule

>>> design/afns_checker.sv
// Port-level checks of the scaler, bound to the top level
`include "aspect_fit_nearest_scaler_defines.svh"

module afns_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);

    // a stalled result word holds
    `AFNS_AST_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // a pixel outside the image is black
    `AFNS_AST_NOW(a_black_out, o_m_tvalid && !o_m_tuser, o_m_tdata == 24'd0)

    // a config write starts the setup, which holds off input
    `AFNS_AST_NEXT(a_cfg_block, i_cfg_valid && o_cfg_ready, !o_s_tready)

endmodule

bind aspect_fit_nearest_scaler afns_checker u_afns_checker (.*);

>>> tb/aspect_fit_nearest_scaler_tb.sv
// Self-checking bench for the aspect-fit nearest-neighbour scaler
module aspect_fit_nearest_scaler_tb;
    import afns_pkg::*;

    localparam logic [2:0] REG_NONE_A = 3'd6;
    localparam logic [2:0] REG_NONE_B = 3'd7;

    typedef struct packed {
        logic        mode;
        logic [11:0] cx;
        logic [11:0] cy;
        logic [23:0] pix;
    } t_word;

    typedef struct packed {
        logic [23:0] pix;
        logic        hit;
    } t_pixel;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic        o_m_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_addr;
    logic [12:0] i_cfg_data;

    aspect_fit_nearest_scaler dut (.*);

    // mirror of the block state
    logic [23:0] img_mem [0:65535];
    logic [12:0] m_ow, m_oh;
    logic [8:0]  m_sw, m_sh;
    logic        m_keep, m_axis;

    t_word  pending_words [$];
    t_pixel expected_pixels [$];
    int     send_idle_pct = 29;
    int     recv_idle_pct = 66;
    int     hold_len = 0;
    int     mismatches = 0;
    int     pixels_seen = 0;
    int     words_sent = 0;
    int     stall_cycles = 0;
    bit     idle_busy = 1'b0;
    bit     hold_go = 1'b0;
    bit     hold_used = 1'b0;

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    function automatic t_pixel map_pixel(input logic [11:0] cx, input logic [11:0] cy);
        t_pixel r;
        longint ow, oh, sw, sh, fw, fh, x0, y0, sx, sy;
        r  = '0;
        ow = (m_ow > OUT_DIM_MAX) ? OUT_DIM_MAX : m_ow;
        oh = (m_oh > OUT_DIM_MAX) ? OUT_DIM_MAX : m_oh;
        sw = (m_sw > SRC_DIM_MAX) ? SRC_DIM_MAX : m_sw;
        sh = (m_sh > SRC_DIM_MAX) ? SRC_DIM_MAX : m_sh;
        if (ow == 0 || oh == 0 || sw == 0 || sh == 0) return r;
        if (cx >= ow || cy >= oh) return r;
        fw = ow; fh = oh; x0 = 0; y0 = 0;
        if (m_keep) begin
            if (!m_axis) begin
                fh = sh * ow / sw;
                y0 = oh / 2 - fh / 2;
            end else begin
                fw = sw * oh / sh;
                x0 = ow / 2 - fw / 2;
            end
        end
        if (fw == 0 || fh == 0) return r;
        // SV longint division truncates toward zero
        sx = (longint'(cx) - x0) * sw / fw;
        sy = (longint'(cy) - y0) * sh / fh;
        if (sx < 0 || sx >= sw || sy < 0 || sy >= sh) return r;
        r.pix = img_mem[sy * SRC_DIM_MAX + sx];
        r.hit = 1'b1;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tuser  <= 1'b0;
            i_s_tdata  <= '0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                words_sent <= words_sent + 1;
                if (i_s_tuser)
                    expected_pixels = {expected_pixels,
                                       map_pixel(i_s_tdata[11:0], i_s_tdata[23:12])};
                else if (i_s_tdata[11:0] < SRC_DIM_MAX && i_s_tdata[23:12] < SRC_DIM_MAX)
                    img_mem[i_s_tdata[23:12] * SRC_DIM_MAX + i_s_tdata[11:0]] =
                        i_s_tdata[47:24];
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_word w;
                    w = pending_words.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= w.mode;
                    i_s_tdata  <= {w.pix, w.cy, w.cx};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_go && !hold_used) begin
            hold_used  <= 1'b1;
            hold_len   <= 300;
            i_m_tready <= 1'b0;
        end else if (hold_len > 0) begin
            hold_len   <= hold_len - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            t_pixel want;
            pixels_seen <= pixels_seen + 1;
            if (expected_pixels.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("unexpected word %h/%b", o_m_tdata, o_m_tuser);
            end else begin
                want = expected_pixels.pop_front();
                if (want.pix !== o_m_tdata || want.hit !== o_m_tuser) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b got %h/%b",
                                 want.pix, want.hit, o_m_tdata, o_m_tuser);
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || idle_busy)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 20000) begin
            $display("** aspect_fit_nearest_scaler: FAILED **");
            $finish;
        end
    end

    task automatic add_word(input t_word w);
        pending_words = {pending_words, w};
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || i_s_tvalid || expected_pixels.size() > 0)
            @(posedge i_clk);
        idle_busy = 1'b1;
        repeat (40) @(posedge i_clk);
        idle_busy = 1'b0;
    endtask

    // leaves the write channel valid; end_cfg drops it
    task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_OUT_WIDTH:   m_ow   = val;
            REG_OUT_HEIGHT:  m_oh   = val;
            REG_SRC_WIDTH:   m_sw   = val[8:0];
            REG_SRC_HEIGHT:  m_sh   = val[8:0];
            REG_KEEP_ASPECT: m_keep = val[0];
            REG_FIT_AXIS:    m_axis = val[0];
            default: ;
        endcase
    endtask

    task automatic end_cfg();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input int ow, input int oh, input int sw, input int sh,
                                input bit keep, input bit axis);
        write_reg(REG_OUT_WIDTH, 13'(ow));
        write_reg(REG_OUT_HEIGHT, 13'(oh));
        write_reg(REG_SRC_WIDTH, 13'(sw));
        write_reg(REG_SRC_HEIGHT, 13'(sh));
        write_reg(REG_KEEP_ASPECT, 13'(keep));
        write_reg(REG_FIT_AXIS, 13'(axis));
        end_cfg();
    endtask

    function automatic t_word mk(input bit md, input int x, input int y, input int p);
        t_word w;
        w.mode = md; w.cx = 12'(x); w.cy = 12'(y); w.pix = 24'(p);
        return w;
    endfunction

    // fetch random pixels of the current frame, mostly inside it
    task automatic queue_fetches(input int n);
        int ow, oh;
        ow = (m_ow > OUT_DIM_MAX) ? OUT_DIM_MAX : m_ow;
        oh = (m_oh > OUT_DIM_MAX) ? OUT_DIM_MAX : m_oh;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0 || ow == 0 || oh == 0)
                add_word(mk(1, $urandom_range(4095), $urandom_range(4095), $urandom));
            else
                add_word(mk(1, $urandom_range(ow - 1), $urandom_range(oh - 1), $urandom));
        end
    endtask

    initial begin
        int ow, oh, sw, sh;
        i_rst_n = 1'b0; i_cfg_valid = 1'b0; i_cfg_addr = '0; i_cfg_data = '0;
        m_ow = 640; m_oh = 480; m_sw = 256; m_sh = 256; m_keep = 0; m_axis = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // a 16x16 corner plus all of row 0 and column 0, so no fetch reads an unwritten entry
        for (int y = 0; y < 16; y++)
            for (int x = 0; x < 16; x++)
                add_word(mk(0, x, y, $urandom));
        for (int k = 16; k < 256; k++) begin
            add_word(mk(0, k, 0, $urandom));
            add_word(mk(0, 0, k, $urandom));
        end
        // ignored loads out of range, then directed fetches on row 0, column 0 and outside the frame
        add_word(mk(0, 256, 3, 24'hFFFFFF));
        add_word(mk(0, 4095, 4095, 24'h000000));
        add_word(mk(1, 0, 0, 0));
        add_word(mk(1, 639, 0, 24'hFFFFFF));
        add_word(mk(1, 0, 479, 0));
        add_word(mk(1, 640, 0, 0));
        add_word(mk(1, 0, 480, 0));
        add_word(mk(1, 4095, 4095, 24'hFFFFFF));
        drain();

        // long hold-off so the pipe fills and the input stalls
        set_geometry(640, 480, 16, 16, 0, 0);
        hold_go = 1'b1;
        queue_fetches(60);
        drain();

        // letterbox with negative offset region and fit on both axes
        set_geometry(4096, 4096, 256, 1, 1, 0); queue_fetches(30); drain();
        set_geometry(100, 4096, 1, 256, 1, 1); queue_fetches(30); drain();
        set_geometry(7, 5, 256, 3, 1, 0); queue_fetches(20); drain(); // fitted height zero
        set_geometry(0, 10, 16, 16, 0, 0); queue_fetches(10); drain(); // zero size
        set_geometry(8191, 8191, 16, 16, 1, 1); queue_fetches(30); drain(); // saturate out
        set_geometry(300, 200, 511, 1, 0, 0); queue_fetches(20); drain(); // saturate src
        set_geometry(200, 300, 1, 511, 1, 1); queue_fetches(20); drain();
        write_reg(REG_NONE_A, 13'h1FFF); write_reg(REG_NONE_B, 13'h0AAA);
        set_geometry(1, 1, 1, 1, 0, 0); queue_fetches(10); drain();

        for (int ph = 0; ph < 24; ph++) begin
            if (ph == 8)  begin send_idle_pct = 66; recv_idle_pct = 29; end
            if (ph == 16) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            ow = ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(1, 300);
            oh = ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(1, 300);
            sw = $urandom_range(16);
            sh = $urandom_range(16);
            set_geometry(ow, oh, sw, sh, $urandom_range(1), $urandom_range(1));
            add_word(mk(0, $urandom_range(4095), $urandom_range(4095), $urandom));
            for (int k = 0; k < 2; k++)
                add_word(mk(0, $urandom_range(15), $urandom_range(15), $urandom));
            queue_fetches(8);
            drain();
        end

        $display("covered %0d words, %0d result pixels over stretch, letterbox and", words_sent,
                 pixels_seen);
        $display("degenerate geometries with varied handshake idling");
        if (mismatches == 0)
            $display("** aspect_fit_nearest_scaler: PASSED **");
        else
            $display("** aspect_fit_nearest_scaler: FAILED **");
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/afns_pkg.sv
design/afns_setup.sv
design/aspect_fit_nearest_scaler.sv
design/afns_checker.sv
tb/aspect_fit_nearest_scaler_tb.sv
